[rtl/core/chs_pkg.sv]
package chs_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int IDX_BITS   = $clog2(MAX_POINTS);
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int PT_BITS    = 2 * COORD_BITS;
  localparam int SUM_BITS   = COORD_BITS + 2;
  localparam int REL_BITS   = COORD_BITS + 3;
  localparam int PROD_BITS  = 2 * REL_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DEGEN = 2'd1;
  localparam logic [1:0] STATUS_OVF   = 2'd2;

  typedef struct packed {
    logic [CNT_BITS-1:0] count;
    logic                ovf;
  } chs_job_t;

  typedef struct packed {
    logic                en;
    logic [IDX_BITS-1:0] addr;
    logic [PT_BITS-1:0]  data;
  } chs_wr_t;

  typedef struct packed {
    logic signed [REL_BITS-1:0] ax;
    logic signed [REL_BITS-1:0] ay;
    logic signed [REL_BITS-1:0] bx;
    logic signed [REL_BITS-1:0] by;
  } chs_ops_t;

endpackage

[rtl/core/chs_ram.sv]
module chs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/chs_front.sv]
module chs_front
  import chs_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic                         last_point,
  output chs_wr_t                      wr,
  output logic                         push,
  output chs_job_t                     push_job
);

  logic [CNT_BITS-1:0] cnt;
  logic                ovf;
  logic                full;

  assign full          = (cnt == CNT_BITS'(MAX_POINTS));
  assign wr.en         = take && !full;
  assign wr.addr       = cnt[IDX_BITS-1:0];
  assign wr.data       = {point_x, point_y};
  assign push          = take && last_point;
  assign push_job.count = full ? cnt : cnt + CNT_BITS'(1);
  assign push_job.ovf   = ovf || full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else if (take) begin
      if (last_point) begin
        cnt <= '0;
        ovf <= 1'b0;
      end else if (full) begin
        ovf <= 1'b1;
      end else begin
        cnt <= cnt + CNT_BITS'(1);
      end
    end
  end

endmodule

[rtl/core/chs_jobq.sv]
module chs_jobq
  import chs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  chs_job_t push_job,
  input  logic     pop,
  output logic     valid,
  output chs_job_t head
);

  chs_job_t   ent [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;

  assign valid = (fill != 2'd0);
  assign head  = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

[rtl/core/chs_cross.sv]
module chs_cross
  import chs_pkg::*;
(
  input  logic                         clk,
  input  chs_ops_t                     ops,
  output logic signed [CROSS_BITS-1:0] cr
);

  logic signed [PROD_BITS-1:0] p1;
  logic signed [PROD_BITS-1:0] p2;

  always_ff @(posedge clk) begin
    p1 <= ops.ax * ops.by;
    p2 <= ops.ay * ops.bx;
  end

  assign cr = CROSS_BITS'(p1) - CROSS_BITS'(p2);

endmodule

[rtl/core/chs_back.sv]
module chs_back
  import chs_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         job_valid,
  input  chs_job_t                     job,
  output logic                         pop,
  output logic                         active,
  output logic [IDX_BITS-1:0]          p_raddr,
  input  logic [PT_BITS-1:0]           p_rdata,
  output logic                         hull_valid,
  output logic signed [COORD_BITS-1:0] hull_x,
  output logic signed [COORD_BITS-1:0] hull_y,
  output logic                         last_vertex,
  output logic [1:0]                   status
);

  typedef enum logic [5:0] {
    S_IDLE, S_CHK, S_ERR, S_MUL,
    S_OR_A, S_OR_B, S_OR_RD, S_OR_T, S_OR_CHK,
    S_SO_RD, S_SO_V, S_SO_J, S_SO_W1, S_SO_W2, S_SO_CMP, S_SO_NX,
    S_DD_RD, S_DD_O, S_DD_P, S_DD_CMP, S_DD_NX,
    S_ST_RD, S_ST_O, S_ST_P,
    S_SC_RD, S_SC_O, S_SC_P, S_SC_TST, S_SC_CMP, S_SC_PUSH,
    S_POP_A, S_POP_C, S_POP_D,
    S_WR_TST, S_WR_END,
    S_EM_RD, S_EM_H, S_EM_P
  } state_t;

  state_t state;
  state_t ret;

  logic [CNT_BITS-1:0] n, k, m, j, kept, top;
  logic [IDX_BITS-1:0] q, s;
  logic [1:0]          err_code;
  logic signed [COORD_BITS-1:0] a_x, a_y, b_x, b_y, c_x, c_y;
  logic signed [COORD_BITS-1:0] t1_x, t1_y, t2_x, t2_y, h0_x, h0_y, s_x, s_y;
  logic signed [SUM_BITS-1:0]   sum_x, sum_y;
  logic signed [REL_BITS-1:0]   v_dx, v_dy, w_dx, w_dy, lk_dx, lk_dy;
  logic [IDX_BITS-1:0] v_idx, w_idx, c_idx;
  logic                wrap;
  chs_ops_t            ops;

  logic signed [CROSS_BITS-1:0] cr;
  logic signed [COORD_BITS-1:0] p_x, p_y;
  logic signed [REL_BITS-1:0]   p_dx, p_dy;
  logic                         before_vw, same_lk, cr_zero, cr_pos;

  logic                o_we, h_we;
  logic [IDX_BITS-1:0] o_waddr, o_raddr, h_waddr, h_raddr;
  logic [IDX_BITS-1:0] o_wdata, o_rdata, h_wdata, h_rdata;

  function automatic logic signed [REL_BITS-1:0] rel_of(
    input logic signed [COORD_BITS-1:0] c,
    input logic signed [SUM_BITS-1:0]   sm
  );
    logic signed [REL_BITS-1:0] ce;
    logic signed [REL_BITS-1:0] se;
    ce = REL_BITS'(c);
    se = REL_BITS'(sm);
    return (ce <<< 1) + ce - se;
  endfunction

  function automatic logic signed [REL_BITS-1:0] diff(
    input logic signed [COORD_BITS-1:0] hi,
    input logic signed [COORD_BITS-1:0] lo
  );
    return REL_BITS'(hi) - REL_BITS'(lo);
  endfunction

  // Upper half plane (including the positive x axis) sorts first.
  function automatic logic half_of(
    input logic signed [REL_BITS-1:0] dx,
    input logic signed [REL_BITS-1:0] dy
  );
    return !((dy > 0) || ((dy == 0) && (dx > 0)));
  endfunction

  function automatic logic [REL_BITS-1:0] mag(input logic signed [REL_BITS-1:0] d);
    return (d < 0) ? REL_BITS'(-d) : REL_BITS'(d);
  endfunction

  chs_cross u_cross (
    .clk (clk),
    .ops (ops),
    .cr  (cr)
  );

  chs_ram #(.WIDTH(IDX_BITS), .DEPTH(MAX_POINTS)) u_order (
    .clk   (clk),
    .we    (o_we),
    .waddr (o_waddr),
    .wdata (o_wdata),
    .raddr (o_raddr),
    .rdata (o_rdata)
  );

  chs_ram #(.WIDTH(IDX_BITS), .DEPTH(MAX_POINTS)) u_stack (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  assign p_x     = $signed(p_rdata[PT_BITS-1:COORD_BITS]);
  assign p_y     = $signed(p_rdata[COORD_BITS-1:0]);
  assign p_dx    = rel_of(p_x, sum_x);
  assign p_dy    = rel_of(p_y, sum_y);
  assign cr_zero = (cr == 0);
  assign cr_pos  = (cr > 0);
  assign pop     = (state == S_IDLE) && job_valid;
  assign active  = (state != S_IDLE);

  // Points on one ray share a sign pattern, so the larger coordinate magnitude is farther.
  always_comb begin
    logic hv;
    logic hw;
    logic far;
    hv  = half_of(v_dx, v_dy);
    hw  = half_of(w_dx, w_dy);
    far = (mag(v_dx) > mag(w_dx)) || (mag(v_dy) > mag(w_dy));
    if (hv != hw) begin
      before_vw = !hv;
    end else if (!cr_zero) begin
      before_vw = cr_pos;
    end else begin
      before_vw = far;
    end
    same_lk = (half_of(lk_dx, lk_dy) == half_of(v_dx, v_dy)) && cr_zero;
  end

  always_comb begin
    p_raddr = k[IDX_BITS-1:0];
    o_raddr = k[IDX_BITS-1:0];
    h_raddr = k[IDX_BITS-1:0];
    o_we    = 1'b0;
    o_waddr = j[IDX_BITS-1:0];
    o_wdata = v_idx;
    h_we    = 1'b0;
    h_waddr = top[IDX_BITS-1:0];
    h_wdata = c_idx;
    unique case (state)
      S_OR_A:  p_raddr = '0;
      S_OR_B:  p_raddr = IDX_BITS'(1);
      S_SO_J:  o_raddr = IDX_BITS'(j - CNT_BITS'(1));
      S_SO_W1: p_raddr = o_rdata;
      S_DD_O:  p_raddr = o_rdata;
      S_ST_O:  p_raddr = o_rdata;
      S_SC_RD: o_raddr = q;
      S_SC_O:  p_raddr = o_rdata;
      S_POP_A: h_raddr = IDX_BITS'(top - CNT_BITS'(2));
      S_POP_C: p_raddr = h_rdata;
      S_EM_RD: h_raddr = k[IDX_BITS-1:0];
      S_EM_H:  p_raddr = h_rdata;
      default: ;
    endcase
    unique case (state)
      S_SO_J: begin
        if (j == '0) begin
          o_we    = 1'b1;
          o_waddr = '0;
        end
      end
      S_SO_CMP: begin
        o_we = 1'b1;
        if (before_vw) o_wdata = w_idx;
      end
      S_DD_P: begin
        if (kept == '0) begin
          o_we    = 1'b1;
          o_waddr = '0;
        end
      end
      S_DD_CMP: begin
        o_we    = !same_lk;
        o_waddr = kept[IDX_BITS-1:0];
      end
      S_SC_PUSH: h_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hull_valid <= 1'b0;
    end else begin
      hull_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            n     <= job.count;
            state <= job.ovf ? S_ERR : S_CHK;
            err_code <= STATUS_OVF;
          end
        end
        S_CHK: begin
          k <= CNT_BITS'(2);
          if (n < CNT_BITS'(3)) begin
            err_code <= STATUS_DEGEN;
            state    <= S_ERR;
          end else begin
            state <= S_OR_A;
          end
        end
        S_ERR: begin
          hull_valid  <= 1'b1;
          hull_x      <= '0;
          hull_y      <= '0;
          last_vertex <= 1'b1;
          status      <= err_code;
          state       <= S_IDLE;
        end
        S_MUL: state <= ret;
        S_OR_A: state <= S_OR_B;
        S_OR_B: begin
          a_x   <= p_x;
          a_y   <= p_y;
          state <= S_OR_RD;
        end
        S_OR_RD: begin
          b_x   <= (k == CNT_BITS'(2)) ? p_x : b_x;
          b_y   <= (k == CNT_BITS'(2)) ? p_y : b_y;
          state <= S_OR_T;
        end
        S_OR_T: begin
          c_x   <= p_x;
          c_y   <= p_y;
          ops   <= '{ax: diff(b_x, a_x), ay: diff(b_y, a_y),
                     bx: diff(p_x, a_x), by: diff(p_y, a_y)};
          ret   <= S_OR_CHK;
          state <= S_MUL;
        end
        S_OR_CHK: begin
          if (!cr_zero) begin
            sum_x <= SUM_BITS'(a_x) + SUM_BITS'(b_x) + SUM_BITS'(c_x);
            sum_y <= SUM_BITS'(a_y) + SUM_BITS'(b_y) + SUM_BITS'(c_y);
            k     <= '0;
            m     <= '0;
            state <= S_SO_RD;
          end else if (k + CNT_BITS'(1) == n) begin
            err_code <= STATUS_DEGEN;
            state    <= S_ERR;
          end else begin
            a_x   <= b_x;
            a_y   <= b_y;
            b_x   <= c_x;
            b_y   <= c_y;
            k     <= k + CNT_BITS'(1);
            state <= S_OR_RD;
          end
        end
        S_SO_RD: state <= S_SO_V;
        S_SO_V: begin
          v_idx <= k[IDX_BITS-1:0];
          v_dx  <= p_dx;
          v_dy  <= p_dy;
          j     <= m;
          state <= ((p_dx == 0) && (p_dy == 0)) ? S_SO_NX : S_SO_J;
        end
        S_SO_J: begin
          if (j == '0) begin
            m     <= m + CNT_BITS'(1);
            state <= S_SO_NX;
          end else begin
            state <= S_SO_W1;
          end
        end
        S_SO_W1: begin
          w_idx <= o_rdata;
          state <= S_SO_W2;
        end
        S_SO_W2: begin
          w_dx  <= p_dx;
          w_dy  <= p_dy;
          ops   <= '{ax: v_dx, ay: v_dy, bx: p_dx, by: p_dy};
          ret   <= S_SO_CMP;
          state <= S_MUL;
        end
        S_SO_CMP: begin
          if (before_vw) begin
            j     <= j - CNT_BITS'(1);
            state <= S_SO_J;
          end else begin
            m     <= m + CNT_BITS'(1);
            state <= S_SO_NX;
          end
        end
        S_SO_NX: begin
          if (k + CNT_BITS'(1) == n) begin
            k     <= '0;
            kept  <= '0;
            state <= (m == '0) ? S_DD_NX : S_DD_RD;
          end else begin
            k     <= k + CNT_BITS'(1);
            state <= S_SO_RD;
          end
        end
        S_DD_RD: state <= S_DD_O;
        S_DD_O: begin
          v_idx <= o_rdata;
          state <= S_DD_P;
        end
        S_DD_P: begin
          v_dx <= p_dx;
          v_dy <= p_dy;
          if (kept == '0) begin
            kept  <= CNT_BITS'(1);
            lk_dx <= p_dx;
            lk_dy <= p_dy;
            state <= S_DD_NX;
          end else begin
            ops   <= '{ax: lk_dx, ay: lk_dy, bx: p_dx, by: p_dy};
            ret   <= S_DD_CMP;
            state <= S_MUL;
          end
        end
        S_DD_CMP: begin
          if (!same_lk) begin
            kept  <= kept + CNT_BITS'(1);
            lk_dx <= v_dx;
            lk_dy <= v_dy;
          end
          state <= S_DD_NX;
        end
        S_DD_NX: begin
          if (m == '0 || k + CNT_BITS'(1) == m) begin
            k <= '0;
            if (kept < CNT_BITS'(3)) begin
              err_code <= STATUS_DEGEN;
              state    <= S_ERR;
            end else begin
              state <= S_ST_RD;
            end
          end else begin
            k     <= k + CNT_BITS'(1);
            state <= S_DD_RD;
          end
        end
        S_ST_RD: state <= S_ST_O;
        S_ST_O:  state <= S_ST_P;
        S_ST_P: begin
          if (k == '0 || p_y < s_y || (p_y == s_y && p_x < s_x)) begin
            s   <= k[IDX_BITS-1:0];
            s_x <= p_x;
            s_y <= p_y;
          end
          if (k + CNT_BITS'(1) == kept) begin
            k     <= '0;
            top   <= '0;
            q     <= (k == '0 || p_y < s_y || (p_y == s_y && p_x < s_x)) ?
                     k[IDX_BITS-1:0] : s;
            state <= S_SC_RD;
          end else begin
            k     <= k + CNT_BITS'(1);
            state <= S_ST_RD;
          end
        end
        S_SC_RD: state <= S_SC_O;
        S_SC_O: begin
          c_idx <= o_rdata;
          state <= S_SC_P;
        end
        S_SC_P: begin
          c_x   <= p_x;
          c_y   <= p_y;
          state <= S_SC_TST;
        end
        S_SC_TST: begin
          wrap <= 1'b0;
          if (top >= CNT_BITS'(2)) begin
            ops   <= '{ax: diff(t1_x, t2_x), ay: diff(t1_y, t2_y),
                       bx: diff(c_x, t2_x), by: diff(c_y, t2_y)};
            ret   <= S_SC_CMP;
            state <= S_MUL;
          end else begin
            state <= S_SC_PUSH;
          end
        end
        S_SC_CMP: begin
          // A non-left turn drops the top vertex; the closing pass works the same way.
          if (!cr_pos) begin
            top   <= top - CNT_BITS'(1);
            t1_x  <= t2_x;
            t1_y  <= t2_y;
            // With two vertices left, the one below the new top is the first vertex.
            if (top == CNT_BITS'(3)) begin
              t2_x <= h0_x;
              t2_y <= h0_y;
            end
            ret   <= wrap ? S_WR_TST : S_SC_TST;
            state <= (top >= CNT_BITS'(4)) ? S_POP_A : (wrap ? S_WR_TST : S_SC_TST);
          end else begin
            state <= wrap ? S_WR_END : S_SC_PUSH;
          end
        end
        S_SC_PUSH: begin
          top  <= top + CNT_BITS'(1);
          t2_x <= t1_x;
          t2_y <= t1_y;
          t1_x <= c_x;
          t1_y <= c_y;
          if (top == '0) begin
            h0_x <= c_x;
            h0_y <= c_y;
          end
          if (k + CNT_BITS'(1) == kept) begin
            state <= S_WR_TST;
          end else begin
            k     <= k + CNT_BITS'(1);
            q     <= (CNT_BITS'(q) + CNT_BITS'(1) == kept) ? '0 : q + IDX_BITS'(1);
            state <= S_SC_RD;
          end
        end
        S_POP_A: state <= S_POP_C;
        S_POP_C: state <= S_POP_D;
        S_POP_D: begin
          t2_x  <= p_x;
          t2_y  <= p_y;
          state <= ret;
        end
        S_WR_TST: begin
          wrap <= 1'b1;
          if (top >= CNT_BITS'(3)) begin
            ops   <= '{ax: diff(t1_x, t2_x), ay: diff(t1_y, t2_y),
                       bx: diff(h0_x, t2_x), by: diff(h0_y, t2_y)};
            ret   <= S_SC_CMP;
            state <= S_MUL;
          end else begin
            state <= S_WR_END;
          end
        end
        S_WR_END: begin
          k <= '0;
          if (top < CNT_BITS'(3)) begin
            err_code <= STATUS_DEGEN;
            state    <= S_ERR;
          end else begin
            state <= S_EM_RD;
          end
        end
        S_EM_RD: state <= S_EM_H;
        S_EM_H:  state <= S_EM_P;
        S_EM_P: begin
          hull_valid  <= 1'b1;
          hull_x      <= p_x;
          hull_y      <= p_y;
          status      <= STATUS_OK;
          last_vertex <= (k + CNT_BITS'(1) == top);
          k           <= k + CNT_BITS'(1);
          state       <= (k + CNT_BITS'(1) == top) ? S_IDLE : S_EM_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/convex_hull_angular_scan.sv]
// Channel   Signals                                   Beat taken when
// --------  ----------------------------------------  ---------------------------
// points    point_x, point_y, last_point              start && !busy at clk edge
// hull      hull_x, hull_y, last_vertex, status       hull_valid high, one cycle
//
// Points load at one per cycle, while busy is low, into the point store; busy
// rises the cycle after the beat that carries last_point and stays high until
// the hull is out. The hull engine reads the point, order and stack memories
// one port at a time through an insertion sort by angle (O(n^2) compares over
// the set), a dedup pass, a scan that drops non-left-turn vertices, and the
// emit of each hull vertex. Reset is synchronous and clears the point count,
// the job queue and the engine state. The receiver cannot stall.
module convex_hull_angular_scan
  import chs_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic                         last_point,
  output logic                         hull_valid,
  output logic signed [COORD_BITS-1:0] hull_x,
  output logic signed [COORD_BITS-1:0] hull_y,
  output logic                         last_vertex,
  output logic [1:0]                   status
);

  logic                take;
  chs_wr_t             wr;
  logic                push;
  chs_job_t            push_job;
  logic                job_valid;
  chs_job_t            job;
  logic                pop;
  logic                active;
  logic [IDX_BITS-1:0] p_raddr;
  logic [PT_BITS-1:0]  p_rdata;

  assign take = start && !busy;
  assign busy = job_valid || active;

  chs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .point_x    (point_x),
    .point_y    (point_y),
    .last_point (last_point),
    .wr         (wr),
    .push       (push),
    .push_job   (push_job)
  );

  chs_ram #(.WIDTH(PT_BITS), .DEPTH(MAX_POINTS)) u_points (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  chs_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .valid    (job_valid),
    .head     (job)
  );

  chs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job         (job),
    .pop         (pop),
    .active      (active),
    .p_raddr     (p_raddr),
    .p_rdata     (p_rdata),
    .hull_valid  (hull_valid),
    .hull_x      (hull_x),
    .hull_y      (hull_y),
    .last_vertex (last_vertex),
    .status      (status)
  );

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last_point) |=> busy)
    else $error("busy did not rise after the last point");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (hull_valid && status != STATUS_OK) |-> (last_vertex && hull_x == 0 && hull_y == 0))
    else $error("error result is not a single zero beat");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    hull_valid |-> (status == STATUS_OK || status == STATUS_DEGEN || status == STATUS_OVF))
    else $error("undefined status code");

endmodule
